### sv/pgw_pkg.sv
// Shared types, constants and helpers for the four-level page table walker.
package pgw_pkg;

   localparam int TABLE_PAGES       = 8;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int STORE_WORDS       = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int PAGE_BITS         = $clog2(TABLE_PAGES);
   localparam int SLICE_BITS        = $clog2(ENTRIES_PER_TABLE);
   localparam int STORE_AW          = PAGE_BITS + SLICE_BITS;

   localparam int VA_W    = 48;
   localparam int PA_W    = 52;
   localparam int DATA_W  = 64;
   localparam int WIDX_W  = 12;
   localparam int ROOT_W  = 3;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_XLATE = 1'b1;

   localparam logic [1:0] PSIZE_4K = 2'd0;
   localparam logic [1:0] PSIZE_2M = 2'd1;
   localparam logic [1:0] PSIZE_1G = 2'd2;

   localparam logic [1:0] LVL_TOP  = 2'd0;
   localparam logic [1:0] LVL_1G   = 2'd1;
   localparam logic [1:0] LVL_2M   = 2'd2;
   localparam logic [1:0] LVL_LEAF = 2'd3;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_HUGE    = 7;

   localparam logic CSR_ROOT = 1'b0;

   typedef struct packed {
      logic              kind;
      logic [VA_W-1:0]   virt_addr;
      logic [WIDX_W-1:0] word_index;
      logic [DATA_W-1:0] word_data;
   } req_type;

   typedef struct packed {
      logic            found;
      logic [PA_W-1:0] phys_addr;
      logic [1:0]      pg_size;
      logic [1:0]      fail_level;
   } rsp_type;

   typedef struct packed {
      logic                is_write;
      logic [VA_W-1:0]     va;
      logic [STORE_AW-1:0] waddr;
      logic [DATA_W-1:0]   wdata;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q2b_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } b2f_type;

   function automatic logic [SLICE_BITS-1:0] va_slice(input logic [VA_W-1:0] va,
                                                      input logic [1:0] lvl);
      logic [SLICE_BITS-1:0] s;
      s = '0;
      unique case (lvl)
         LVL_TOP:  s = va[39 +: SLICE_BITS];
         LVL_1G:   s = va[30 +: SLICE_BITS];
         LVL_2M:   s = va[21 +: SLICE_BITS];
         LVL_LEAF: s = va[12 +: SLICE_BITS];
         default:  s = '0;
      endcase
      return s;
   endfunction

endpackage

### sv/four_level_page_table_walker.sv
// Top level of the four-level page table walker: root register port and front/back ends.
//
// Request channel (req_valid, req_stall, req_data): kind 0 writes one 64-bit
// table word at word_index, kind 1 translates virt_addr. A transfer happens
// at a rising edge with valid high and stall low. Writes give no response.
// Response channel (rsp_valid, rsp_stall, rsp_data): one transfer per
// translation, in request order, carrying found, phys_addr, pg_size and
// fail_level. While the receiver stalls, the response register holds.
// Configuration: APB-style register root_table_page at byte address 0.
// A two-entry command queue decouples request intake from the walk.
// After reset the whole table store is cleared one word per cycle,
// with req_stall high; configuration writes are taken throughout.
// A write needs no walk: it is one store write made from the idle state. A translation
// issues a read of the top-level entry, then one read for each further level visited,
// through the single synchronous read port of the table store; the response
// is registered, loaded once the walk ends and the response register is free.
// Reset empties the queue and clears the response valid flag and root_table_page.
module four_level_page_table_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pgw_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pgw_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pgw_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pgw_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pgw_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import pgw_pkg::*;

   logic [ROOT_W-1:0] root_ff, root_in;
   logic              csr_wr;
   q2b_type           q2b;
   b2f_type           b2f;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      root_in = root_ff;
      if (csr_wr && csr_paddr[2] == CSR_ROOT) begin
         root_in = csr_pwdata[ROOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_ROOT) ? CSR_DW'(root_ff) : '0;

   pgw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q2b       (q2b),
      .b2f       (b2f)
   );

   pgw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .root_page (root_ff),
      .q2b       (q2b),
      .b2f       (b2f),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/pgw_front.sv
// Front end: accepts request transfers, classifies them and queues commands.
module pgw_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pgw_pkg::req_type req_data,
   output pgw_pkg::q2b_type q2b,
   input  pgw_pkg::b2f_type b2f
);
   import pgw_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cmd_c;
   logic       keep_c;
   logic       push;

   always_comb begin
      cmd_c.is_write = (req_data.kind == KIND_WRITE);
      cmd_c.va       = req_data.virt_addr;
      cmd_c.waddr    = STORE_AW'(req_data.word_index);
      cmd_c.wdata    = req_data.word_data;
      keep_c         = (req_data.kind == KIND_XLATE) ||
                       (32'(req_data.word_index) < 32'(STORE_WORDS));
   end

   assign req_stall = (cnt_ff == 2'd2) || b2f.clearing;
   assign push      = req_valid && !req_stall && keep_c;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         q_in[wptr_ff] = cmd_c;
         wptr_in       = !wptr_ff;
      end
      if (b2f.pop) begin
         rptr_in = !rptr_ff;
      end
      if (push && !b2f.pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && b2f.pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign q2b.valid = (cnt_ff != 2'd0);
   assign q2b.cmd   = q_ff[rptr_ff];

endmodule

### sv/pgw_back.sv
// Back end: table store, clearing pass, level-by-level walk and result register.
module pgw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pgw_pkg::ROOT_W-1:0]    root_page,
   input  pgw_pkg::q2b_type              q2b,
   output pgw_pkg::b2f_type              b2f,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pgw_pkg::rsp_type              rsp_data
);
   import pgw_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [DATA_W-1:0]   store_mem [STORE_WORDS];
   logic [DATA_W-1:0]   rdata_ff;

   logic [1:0]          state_ff, state_in;
   logic [STORE_AW-1:0] clr_ff, clr_in;
   logic [1:0]          level_ff, level_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [STORE_AW-1:0] wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic                rd_en;
   logic [STORE_AW-1:0] rd_addr;
   logic                pop;
   logic                load_rsp;

   logic                present;
   logic                huge;
   logic                walk_done;
   logic                out_free;
   logic [PAGE_BITS-1:0] next_page;
   logic [PAGE_BITS-1:0] root_pg;
   rsp_type             res_c;

   assign present   = rdata_ff[BIT_PRESENT];
   assign huge      = rdata_ff[BIT_HUGE];
   assign next_page = rdata_ff[12 +: PAGE_BITS];
   assign root_pg   = PAGE_BITS'(root_page);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      res_c      = '0;
      walk_done  = 1'b0;
      if (!present) begin
         walk_done        = 1'b1;
         res_c.fail_level = level_ff;
      end else if (level_ff == LVL_1G && huge) begin
         walk_done       = 1'b1;
         res_c.found     = 1'b1;
         res_c.phys_addr = {rdata_ff[51:30], va_ff[29:0]};
         res_c.pg_size   = PSIZE_1G;
      end else if (level_ff == LVL_2M && huge) begin
         walk_done       = 1'b1;
         res_c.found     = 1'b1;
         res_c.phys_addr = {rdata_ff[51:21], va_ff[20:0]};
         res_c.pg_size   = PSIZE_2M;
      end else if (level_ff == LVL_LEAF) begin
         walk_done       = 1'b1;
         res_c.found     = 1'b1;
         res_c.phys_addr = {rdata_ff[51:12], va_ff[11:0]};
         res_c.pg_size   = PSIZE_4K;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      level_in = level_ff;
      va_in    = va_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      pop      = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == STORE_AW'(STORE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q2b.valid) begin
               pop = 1'b1;
               if (q2b.cmd.is_write) begin
                  wr_en   = 1'b1;
                  wr_addr = q2b.cmd.waddr;
                  wr_data = q2b.cmd.wdata;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = {root_pg, va_slice(q2b.cmd.va, LVL_TOP)};
                  va_in    = q2b.cmd.va;
                  level_in = LVL_TOP;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = {next_page, va_slice(va_ff, level_ff + 2'd1)};
               level_in = level_ff + 2'd1;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_c;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      va_ff       <= va_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign b2f.pop      = pop;
   assign b2f.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule
